// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the top-k insertion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    `ASSERT_AT(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== sv/stk_pkg.sv =====
// Package with the payload, link and control types of the top-k insertion block.
package stk_pkg;

    localparam int SCORE_W = 16;
    localparam int LIST_IDX_W = 2;
    localparam int POSITION_W = 4;

    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic [LIST_IDX_W-1:0] list_index;
        score_t                score;
    } stk_in_t;

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic                  kept;
    } stk_out_t;

    // What one cell hands to the next: its entry for the selected list and
    // whether that entry is greater than the offered score.
    typedef struct packed {
        score_t entry;
        logic   gt;
    } stk_link_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic    wr_en;
        stk_in_t req;
    } stk_cell_ctl_t;

endpackage

// ===== sv/sorted_top_k_insert.sv =====
// Top level of the sorted top-k insertion block: request control and cell chain.
//
// The block keeps NUM_LISTS ascending lists of LIST_DEPTH 16-bit scores. A
// request on the s_ channel names a list and offers a score; the score goes in
// after every entry less than or equal to it, larger entries move down one
// rank and the last entry of the list falls off.
// Each request yields exactly one result on the m_ channel: the rank at which
// the score was placed and a kept flag. When the score is not kept, or the
// list index names no list, position equals LIST_DEPTH (modulo 16) and kept
// is low, and the lists are left as they were.
// A request is taken into a holding register; once the output register can
// take a result, the chain of rank cells reads the selected list, compares
// and writes the shifted list back, while the result is loaded into the
// output register. A new request is accepted only once the held one has
// been processed by the read-compare-write pass.
// A waiting result does not block the next request from being taken; only
// its processing waits until the output register is free.
// At reset every entry of every list holds EMPTY_MARK and both channels are
// idle; the block is ready for requests in the first cycle after reset.
`include "assert_macros.svh"

module sorted_top_k_insert #(
    parameter int NUM_LISTS  = 4,
    parameter int LIST_DEPTH = 8,
    parameter int EMPTY_MARK = 1000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  stk_pkg::stk_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output stk_pkg::stk_out_t m_data
);

    localparam int POS_W = $clog2(LIST_DEPTH + 1);

    // Request holding register and busy flag.
    logic              busy_reg, busy_next;
    stk_pkg::stk_in_t  req_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    stk_pkg::stk_out_t out_reg, out_next;

    logic                   fire;
    logic                   in_range;
    stk_pkg::stk_cell_ctl_t ctl;
    stk_pkg::stk_link_t     links [LIST_DEPTH+1];
    logic [LIST_DEPTH-1:0]  first;
    logic [POS_W-1:0]       pos_or;
    logic [POS_W-1:0]       pos;

    assign s_ready  = !busy_reg;
    // The held request is processed once the output register can take its
    // result.
    assign fire     = busy_reg && (!out_valid_reg || m_ready);
    assign in_range = 32'(req_reg.list_index) < 32'(NUM_LISTS);

    assign ctl.wr_en = fire && in_range;
    assign ctl.req   = req_reg;

    // The head of the chain sees no greater entry ahead of it.
    assign links[0].entry = '0;
    assign links[0].gt    = 1'b0;

    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        stk_cell #(
            .NUM_LISTS (NUM_LISTS),
            .EMPTY_MARK(EMPTY_MARK)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .ctl    (ctl),
            .prev   (links[k]),
            .link   (links[k+1])
        );
        // The list is sorted, so the greater flags form a tail; its first
        // bit marks the insert rank.
        assign first[k] = links[k+1].gt && !links[k].gt;
    end

    always_comb begin
        pos_or = '0;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            if (first[k]) begin
                pos_or = pos_or | POS_W'(k);
            end
        end
        if (in_range && (|first)) begin
            pos = pos_or;
        end else begin
            pos = POS_W'(LIST_DEPTH);
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            busy_next         = 1'b0;
            out_valid_next    = 1'b1;
            out_next.position = stk_pkg::POSITION_W'(pos);
            out_next.kept     = in_range && (|first);
        end
        if (s_valid && s_ready) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A processed request always leaves a result in the output register.
    `ASSERT_AT(a_fire_gives_result, aclk, aresetn,
        fire |=> m_valid,
        "processed request lost its result")
    // A new result only appears after a request was held.
    `ASSERT_AT(a_result_from_request, aclk, aresetn,
        $rose(m_valid) |-> $past(busy_reg),
        "result without request")
    // A score that is not kept reports the list depth.
    `ASSERT_AT(a_not_kept_pos, aclk, aresetn,
        (m_valid && !m_data.kept) |-> (m_data.position == stk_pkg::POSITION_W'(LIST_DEPTH)),
        "bad position for a dropped score")
    // A held request waits while the output register is still occupied.
    `ASSERT_AT(a_hold_on_stall, aclk, aresetn,
        (busy_reg && m_valid && !m_ready) |=> busy_reg,
        "request dropped while result waits")

endmodule

// ===== sv/stk_cell.sv =====
// One rank of the chain: holds that rank's entry of every list.
module stk_cell #(
    parameter int NUM_LISTS  = 4,
    parameter int EMPTY_MARK = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  stk_pkg::stk_cell_ctl_t ctl,
    input  stk_pkg::stk_link_t    prev,
    output stk_pkg::stk_link_t    link
);

    localparam int LIST_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

    stk_pkg::score_t   row_reg [NUM_LISTS];
    stk_pkg::score_t   entry_next;
    stk_pkg::score_t   cur;
    logic [LIST_W-1:0] idx;
    logic              gt;

    assign idx = LIST_W'(ctl.req.list_index);
    assign cur = row_reg[idx];
    assign gt  = cur > ctl.req.score;

    // A greater entry ahead of us means the whole tail moves down a rank;
    // otherwise the first greater entry is where the new score lands.
    always_comb begin
        if (prev.gt) begin
            entry_next = prev.entry;
        end else if (gt) begin
            entry_next = ctl.req.score;
        end else begin
            entry_next = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                row_reg[i] <= stk_pkg::SCORE_W'(EMPTY_MARK);
            end
        end else if (ctl.wr_en) begin
            row_reg[idx] <= entry_next;
        end
    end

    assign link.entry = cur;
    assign link.gt    = gt;

endmodule

// ===== bench/top_k_checker.sv =====
// Checker for the sorted top-k insertion block: predicts each result and compares it.
module top_k_checker #(
    parameter int NUM_LISTS  = 4,
    parameter int LIST_DEPTH = 8,
    parameter int EMPTY_MARK = 1000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  stk_pkg::stk_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  stk_pkg::stk_out_t m_data,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of every list, best score first.
    stk_pkg::score_t   ranks [NUM_LISTS][LIST_DEPTH];
    stk_pkg::stk_out_t expected_results [$];
    int                fails = 0;
    int                waiting = 0;

    assign fail_count = fails;
    assign pending    = waiting;

    // Places a score after every entry less than or equal to it and returns the rank.
    function automatic stk_pkg::stk_out_t place_score(stk_pkg::stk_in_t req);
        int                slot;
        stk_pkg::stk_out_t res;
        slot = LIST_DEPTH;
        if (int'(req.list_index) < NUM_LISTS) begin
            while (slot > 0 && ranks[req.list_index][slot-1] > req.score)
                slot--;
            if (slot < LIST_DEPTH) begin
                for (int k = LIST_DEPTH - 1; k > slot; k--)
                    ranks[req.list_index][k] = ranks[req.list_index][k-1];
                ranks[req.list_index][slot] = req.score;
            end
        end
        res.position = slot[stk_pkg::POSITION_W-1:0];
        res.kept     = (slot < LIST_DEPTH);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        stk_pkg::stk_out_t want;
        if (!aresetn) begin
            foreach (ranks[l, e])
                ranks[l][e] = stk_pkg::score_t'(EMPTY_MARK);
            expected_results.delete();
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(place_score(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result position=%0d kept=%0b",
                             $time, m_data.position, m_data.kept);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.position !== want.position) begin
                        fails++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, m_data.position);
                    end
                    if (m_data.kept !== want.kept) begin
                        fails++;
                        $display("%0t: kept expected %0b actual %0b",
                                 $time, want.kept, m_data.kept);
                    end
                end
            end
        end
        waiting = expected_results.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the sorted top-k insertion block: stimulus, reset and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LISTS  = 4;
    localparam int LIST_DEPTH = 8;
    localparam int EMPTY_MARK = 1000;
    localparam int N_RANDOM   = 1425;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    stk_pkg::stk_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    stk_pkg::stk_out_t m_data;
    int                fail_count;
    int                pending;

    // When set, neither the request side nor the result side inserts idle cycles.
    bit no_idle = 1'b0;

    sorted_top_k_insert #(
        .NUM_LISTS (NUM_LISTS),
        .LIST_DEPTH(LIST_DEPTH),
        .EMPTY_MARK(EMPTY_MARK)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // The checker sits beside the block, watches both channels and counts failures.
    top_k_checker #(
        .NUM_LISTS (NUM_LISTS),
        .LIST_DEPTH(LIST_DEPTH),
        .EMPTY_MARK(EMPTY_MARK)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Guards against a hung handshake. The slowest legal run is well under
    // 200 us, so ten times that leaves plenty of margin.
    initial begin
        #2000000;
        $display("FAIL sorted_top_k_insert");
        $finish;
    end

    // Presents one request from a falling edge and holds it until it has been
    // taken. Returns at the falling edge after acceptance, with valid still
    // high, so that a following request can replace the payload without a gap.
    task automatic offer(input logic [stk_pkg::LIST_IDX_W-1:0] list,
                         input int unsigned value);
        s_valid = 1'b1;
        s_data  = '{list_index: list, score: stk_pkg::score_t'(value)};
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // A request, sometimes preceded by a short idle burst on the request side.
    task automatic request(input logic [stk_pkg::LIST_IDX_W-1:0] list,
                           input int unsigned value);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        offer(list, value);
    endtask

    // Random scores. Lists only ever hold values below the empty marker, and
    // they fill with ever smaller values, so most scores follow a ceiling that
    // falls over the run. That keeps insertions landing at all ranks rather
    // than being dropped once the lists are full of small values. The rest are
    // full-range values, tiny values that produce ties, and values around
    // the marker itself.
    function automatic int unsigned pick_score(input int idx);
        int ceiling;
        int floor_v;
        ceiling = EMPTY_MARK - (idx * EMPTY_MARK) / N_RANDOM;
        floor_v = (ceiling > 48) ? ceiling - 48 : 0;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 65535);
            2:       return $urandom_range(0, 7);
            3:       return $urandom_range(EMPTY_MARK - 2, EMPTY_MARK + 2);
            default: return $urandom_range(floor_v, ceiling + 8);
        endcase
    endfunction

    // Result side: ready drops at random, except while
    // no_idle is set, when it stays high throughout.
    initial begin : result_sink
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!no_idle && $urandom_range(0, 2) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    end

    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. List 0: the smallest score goes to the top, the
        // largest score and the marker itself are not kept, a score just under
        // the marker lands behind the zero, and a repeated zero goes after the first.
        request(2'd0, 0);
        request(2'd0, 65535);
        request(2'd0, EMPTY_MARK);
        request(2'd0, EMPTY_MARK - 1);
        request(2'd0, 0);
        // List 1: a score just above the marker, then three equal scores that
        // must stack up in arrival order at ranks 0, 1 and 2.
        request(2'd1, EMPTY_MARK + 1);
        repeat (3) request(2'd1, 500);
        // List 2: filled from the back so that every request enters at rank 0
        // and pushes the rest down. Once it is full of better scores, neither a
        // larger score nor one equal to the last entry is kept, while a zero
        // still enters at the top and the last entry falls off.
        for (int v = LIST_DEPTH; v >= 1; v--)
            request(2'd2, v);
        request(2'd2, LIST_DEPTH + 1);
        request(2'd2, LIST_DEPTH);
        request(2'd2, 0);
        // List 3: alternating bit patterns and both extremes of the score.
        request(2'd3, 16'hFFFF);
        request(2'd3, 16'h0000);
        request(2'd3, 16'h5555);
        request(2'd3, 16'h2AAA);

        // Random part, with one quiet stretch in the middle and a quiet tail.
        for (int i = 0; i < N_RANDOM; i++) begin
            no_idle = (i >= 600 && i < 700) || (i >= N_RANDOM - 150);
            request(2'($urandom_range(0, NUM_LISTS - 1)), pick_score(i));
        end
        s_valid = 1'b0;

        // Drain every outstanding result, then give the block a few cycles
        // in case anything stray appears on the result channel.
        while (pending != 0)
            @(negedge aclk);
        repeat (16) @(negedge aclk);

        if (fail_count == 0) begin
            $display("PASS sorted_top_k_insert");
        end else begin
            $display("FAIL sorted_top_k_insert");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/stk_pkg.sv
sv/stk_cell.sv
sv/sorted_top_k_insert.sv
bench/top_k_checker.sv
bench/tb.sv
